[hw/rtl/max_frequency_tracker_macros.svh]
// Assertion macros for the max_frequency_tracker block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MAX_FREQUENCY_TRACKER_MACROS_SVH
`define MAX_FREQUENCY_TRACKER_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define MFT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent is checked in the cycle after the antecedent.
`define MFT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mft_pkg.sv]
// Package for the max_frequency_tracker block: field widths, default sizes
// and the controller state type. No dependencies.
package mft_pkg;

	localparam int ID_W            = 10;
	localparam int CHANGE_W        = 32;
	localparam int OUT_W           = 40;
	localparam int NUM_IDS_DEF     = 1024;
	localparam int COUNT_BITS_DEF  = 40;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_UPD   = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

[hw/rtl/mft_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. No dependencies.
module mft_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/mft_sat_add.sv]
// Saturating count update: adds a signed change to an unsigned count and
// clamps the result to the count range. Depends on mft_pkg.
module mft_sat_add #(
	parameter int COUNT_BITS = mft_pkg::COUNT_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0]              old_count,
	input  logic signed [mft_pkg::CHANGE_W-1:0] change,
	output logic [COUNT_BITS-1:0]              new_count
);

	localparam int SUM_W = (COUNT_BITS > mft_pkg::CHANGE_W) ?
		COUNT_BITS + 2 : mft_pkg::CHANGE_W + 2;

	logic [SUM_W-1:0] old_ext;
	logic [SUM_W-1:0] chg_ext;
	logic [SUM_W-1:0] sum_w;
	logic [SUM_W-1:0] max_ext;
	logic             below;
	logic             above;

	assign old_ext = {{(SUM_W-COUNT_BITS){1'b0}}, old_count};
	assign chg_ext = {{(SUM_W-mft_pkg::CHANGE_W){change[mft_pkg::CHANGE_W-1]}}, change};
	assign max_ext = {{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
	// The sum is wide enough that it never wraps, so its top bit is the sign.
	assign sum_w   = old_ext + chg_ext;
	assign below   = sum_w[SUM_W-1];
	assign above   = !below && (sum_w > max_ext);

	always_comb begin
		if (below) begin
			new_count = '0;
		end else if (above) begin
			new_count = {COUNT_BITS{1'b1}};
		end else begin
			new_count = sum_w[COUNT_BITS-1:0];
		end
	end

endmodule

[hw/rtl/max_frequency_tracker.sv]
// Top level of the max_frequency_tracker block: controller, count table and
// running maximum. Depends on mft_pkg, mft_ram, mft_sat_add and the macro header.
//
// Usage: an input item (item_id, change) is taken on in_valid & in_ready.
// The change is added to the count of item_id, saturating at 0 and at the
// largest COUNT_BITS-bit value, and one result item max_count, the largest
// count over all IDs after the update, is offered on out_valid / out_ready.
// An item_id at or above NUM_IDS leaves the table alone and returns the
// current maximum.
// The count is read at the accepting edge and written back in the next
// cycle (ST_UPD) with the maximum updated; out_valid is then set from
// ST_DONE once the output register is free. When the ID that held the
// maximum decreases below it, the table is rescanned through the read
// port, one entry a cycle. One item is in flight at a time; in_ready is
// high only while the controller is idle, so a new item is not taken
// before the last one has left its final state.
// After reset the table is cleared by a pass over all NUM_IDS entries, during which
// in_ready stays low. A stalled receiver holds the finished result in the
// output register; the next item may be accepted meanwhile and waits in
// its final state until the register frees.
`include "max_frequency_tracker_macros.svh"

module max_frequency_tracker #(
	parameter int NUM_IDS    = mft_pkg::NUM_IDS_DEF,
	parameter int COUNT_BITS = mft_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mft_pkg::ID_W-1:0]            item_id,
	input  logic signed [mft_pkg::CHANGE_W-1:0] change,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mft_pkg::OUT_W-1:0]           max_count
);

	localparam int IDX_W = $clog2(NUM_IDS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);

	mft_pkg::state_t state_q;

	logic [IDX_W-1:0]            sc_q;
	logic                        issued_q;
	logic                        rv_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic [IDX_W-1:0]            id_q;
	logic signed [mft_pkg::CHANGE_W-1:0] change_q;
	logic [COUNT_BITS-1:0]       cur_max_q;
	logic [IDX_W-1:0]            holder_q;
	logic [COUNT_BITS-1:0]       best_q;
	logic [IDX_W-1:0]            where_q;
	logic                        out_valid_q;
	logic [mft_pkg::OUT_W-1:0]   max_count_q;

	logic [31:0]           id_wide;
	logic                  id_in_range;
	logic [IDX_W-1:0]      id_idx;
	logic                  accept;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] new_count;
	logic                  rd_gt;
	logic [COUNT_BITS-1:0] best_n;
	logic [IDX_W-1:0]      where_n;
	logic                  out_free;
	logic [63:0]           cur_wide;

	assign id_wide     = 32'(item_id);
	assign id_in_range = id_wide < 32'(NUM_IDS);
	assign id_idx      = id_wide[IDX_W-1:0];
	assign in_ready    = (state_q == mft_pkg::ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign cur_wide    = 64'(cur_max_q);

	// Only one item is in flight, so the write-back in ST_UPD never overlaps a used
	// read of the same entry; a scan read in the next cycle sees the new value.
	assign ram_we    = (state_q == mft_pkg::ST_CLEAR) || (state_q == mft_pkg::ST_UPD);
	assign ram_waddr = (state_q == mft_pkg::ST_CLEAR) ? sc_q : id_q;
	assign ram_wdata = (state_q == mft_pkg::ST_CLEAR) ? '0 : new_count;
	assign ram_raddr = (state_q == mft_pkg::ST_IDLE) ? id_idx : sc_q;

	mft_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_IDS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mft_sat_add #(
		.COUNT_BITS(COUNT_BITS)
	) u_sat_add (
		.old_count(ram_rdata),
		.change   (change_q),
		.new_count(new_count)
	);

	// Strict compare keeps the lowest index among equal counts.
	assign rd_gt   = ram_rdata > best_q;
	assign best_n  = rd_gt ? ram_rdata : best_q;
	assign where_n = rd_gt ? idx_s1 : where_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mft_pkg::ST_CLEAR;
			sc_q        <= '0;
			issued_q    <= 1'b0;
			rv_s1       <= 1'b0;
			idx_s1      <= '0;
			id_q        <= '0;
			change_q    <= '0;
			cur_max_q   <= '0;
			holder_q    <= '0;
			best_q      <= '0;
			where_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mft_pkg::ST_CLEAR: begin
					if (sc_q == LAST_IDX) begin
						sc_q    <= '0;
						state_q <= mft_pkg::ST_IDLE;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				mft_pkg::ST_IDLE: begin
					if (accept) begin
						id_q     <= id_idx;
						change_q <= change;
						state_q  <= id_in_range ? mft_pkg::ST_UPD : mft_pkg::ST_DONE;
					end
				end
				mft_pkg::ST_UPD: begin
					if (new_count >= cur_max_q) begin
						cur_max_q <= new_count;
						holder_q  <= id_q;
						state_q   <= mft_pkg::ST_DONE;
					end else if (id_q == holder_q) begin
						sc_q     <= '0;
						issued_q <= 1'b0;
						best_q   <= '0;
						where_q  <= '0;
						state_q  <= mft_pkg::ST_SCAN;
					end else begin
						state_q <= mft_pkg::ST_DONE;
					end
				end
				mft_pkg::ST_SCAN: begin
					if (!issued_q) begin
						rv_s1  <= 1'b1;
						idx_s1 <= sc_q;
						if (sc_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							sc_q <= sc_q + 1'b1;
						end
					end
					if (rv_s1) begin
						best_q  <= best_n;
						where_q <= where_n;
						if (idx_s1 == LAST_IDX) begin
							cur_max_q <= best_n;
							holder_q  <= where_n;
							sc_q      <= '0;
							state_q   <= mft_pkg::ST_DONE;
						end
					end
				end
				mft_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= mft_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mft_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mft_pkg::ST_DONE && out_free) begin
			max_count_q <= cur_wide[mft_pkg::OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign max_count = max_count_q;

	`MFT_ASSERT_NEXT(a_max_no_drop, state_q != mft_pkg::ST_SCAN, cur_max_q >= $past(cur_max_q), "running maximum fell outside a rescan")
	`MFT_ASSERT_NEXT(a_scan_monotone, state_q == mft_pkg::ST_SCAN && rv_s1, best_q >= $past(best_q), "scan best value decreased")
	`MFT_ASSERT_SAME(a_result_from_done, $rose(out_valid_q), $past(state_q == mft_pkg::ST_DONE), "result loaded outside the final state")

endmodule

[bench/tb_max_frequency_tracker.sv]
// Self-checking testbench for max_frequency_tracker: directed, random and
// saturation items with a local model of the count table and its maximum.
// Depends on mft_pkg and the max_frequency_tracker RTL.
`timescale 1ns / 1ps

module tb_max_frequency_tracker;

	localparam int ID_W = mft_pkg::ID_W;
	localparam int CHANGE_W = mft_pkg::CHANGE_W;
	localparam int OUT_W = mft_pkg::OUT_W;
	localparam int N_IDS = mft_pkg::NUM_IDS_DEF;
	localparam logic [OUT_W-1:0] COUNT_TOP = {OUT_W{1'b1}};
	localparam int CYCLE_LIMIT = 6000000;
	localparam int RANDOM_ITEMS = 40;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [ID_W-1:0]            item_id = '0;
	logic signed [CHANGE_W-1:0] change = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [OUT_W-1:0]           max_count;

	// Local copy of the count table and its running maximum.
	logic [OUT_W-1:0] tally [N_IDS];
	logic [OUT_W-1:0] peak = '0;
	logic [ID_W-1:0]  peak_id = '0;
	logic [OUT_W-1:0] peak_q [$];

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned rescans = 0;
	int unsigned floor_clamps = 0;
	int unsigned top_clamps = 0;

	// Sender and receiver idling controls.
	int unsigned gap_max = 4;
	int unsigned burst_left = 0;
	bit          rx_always = 1'b0;
	int unsigned rx_period = 4;
	int unsigned rx_open = 3;
	int unsigned rx_tick = 0;

	logic [ID_W-1:0] hot_ids [8];

	max_frequency_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.item_id(item_id),
		.change(change),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.max_count(max_count)
	);

	always #5 clk = ~clk;

	// Applies one change to the table and returns the maximum that follows.
	function automatic logic [OUT_W-1:0] update_tally(input logic [ID_W-1:0] id,
			input logic signed [CHANGE_W-1:0] delta);
		logic [63:0] prior;
		logic [63:0] mag;
		logic [63:0] sum;
		logic [OUT_W-1:0] best;
		logic [ID_W-1:0] best_id;
		prior = {24'b0, tally[id]};
		if (delta[CHANGE_W-1]) begin
			mag = 64'h1_0000_0000 - {32'b0, delta};
			if (mag > prior) begin
				sum = '0;
				floor_clamps++;
			end else begin
				sum = prior - mag;
			end
		end else begin
			sum = prior + {32'b0, delta};
			if (sum > {24'b0, COUNT_TOP}) begin
				sum = {24'b0, COUNT_TOP};
				top_clamps++;
			end
		end
		tally[id] = sum[OUT_W-1:0];
		if (tally[id] >= peak) begin
			peak = tally[id];
			peak_id = id;
		end else if (id == peak_id) begin
			// The holder dropped: the lowest index with the largest count wins.
			best = '0;
			best_id = '0;
			for (int i = 0; i < N_IDS; i++) begin
				if (tally[i] > best) begin
					best = tally[i];
					best_id = ID_W'(i);
				end
			end
			peak = best;
			peak_id = best_id;
			rescans++;
		end
		return peak;
	endfunction

	task automatic idle_cycles(input int unsigned n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
			item_id <= ID_W'($urandom);
			change <= CHANGE_W'($urandom);
		end
	endtask

	task automatic send_item(input logic [ID_W-1:0] id, input logic signed [CHANGE_W-1:0] delta);
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				idle_cycles($urandom_range(1, gap_max));
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		item_id <= id;
		change <= delta;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		peak_q.push_back(update_tally(id, delta));
		items_sent++;
	endtask

	// Holds the sender off until every outstanding result has come back.
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (peak_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed;
		gap_max = 0;
		rx_always = 1'b1;
		send_item(10'd0, 32'sd0);
		send_item(10'd1023, 32'sd5);
		send_item(10'd0, -32'sd1);
		send_item(10'd1023, 32'sh8000_0000);
		send_item(10'd512, 32'sh7FFF_FFFF);
		send_item(10'd3, 32'sh7FFF_FFFF);
		send_item(10'd3, -32'sd1);
		send_item(10'd512, 32'sh8000_0000);
		send_item(10'h2AA, 32'sh5555_5555);
		send_item(10'h155, 32'shAAAA_AAAA);
		send_item(10'h155, 32'sh2AAA_AAAA);
		send_item(10'd50, 32'sh5555_5555);
		send_item(10'd50, -32'sd1);
		send_item(10'd900, 32'sh5555_5555);
		send_item(10'd900, -32'sd2);
		send_item(10'h2AA, 32'sh8000_0000);
		send_item(10'd900, 32'sh8000_0000);
		send_item(10'd50, 32'sh8000_0000);
		gap_max = 3;
		rx_always = 1'b0;
		send_item(10'h155, -32'sd1);
		send_item(10'd1, 32'sd1);
		drain();
	endtask

	function automatic logic [ID_W-1:0] pick_id;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return hot_ids[$urandom_range(0, 7)];
		else if (r < 68)
			return ($urandom_range(0, 1) != 0) ? ID_W'(0) : ID_W'(N_IDS - 1);
		return ID_W'($urandom);
	endfunction

	function automatic logic signed [CHANGE_W-1:0] pick_change;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CHANGE_W'($urandom_range(1, 1000));
		else if (r < 65)
			return -CHANGE_W'($urandom_range(1, 1000));
		else if (r < 80)
			return CHANGE_W'($urandom);
		else if (r < 90)
			return CHANGE_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
		else if (r < 95)
			return 32'sh8000_0000;
		return 32'sd0;
	endfunction

	// Four stretches with different idling on both sides, drained in between.
	task automatic test_random;
		for (int i = 0; i < 8; i++)
			hot_ids[i] = ID_W'($urandom);
		for (int seg = 0; seg < 4; seg++) begin
			case (seg)
				0: begin gap_max = 5; rx_always = 1'b0; end
				1: begin gap_max = 0; rx_always = 1'b1; end
				2: begin gap_max = 8; rx_always = 1'b0; end
				default: begin gap_max = 0; rx_always = 1'b0; end
			endcase
			repeat (RANDOM_ITEMS / 4)
				send_item(pick_id(), pick_change());
			drain();
		end
	endtask

	// Drives one ID past the top of the count range, then steps it back down.
	task automatic test_saturate;
		logic [ID_W-1:0] id;
		id = ID_W'($urandom);
		gap_max = 2;
		repeat (515)
			send_item(id, 32'sh7FFF_FFFF);
		send_item(id, -32'sd1);
		send_item(ID_W'(id + 1), 32'sh7FFF_FFFF);
		send_item(id, 32'sh8000_0000);
		send_item(id, 32'sh7FFF_FFFF);
		drain();
	endtask

	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 97 == 0) begin
			rx_period = $urandom_range(1, 7);
			rx_open = $urandom_range(1, rx_period);
		end
		out_ready <= rx_always || ((rx_tick % rx_period) < rx_open);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, peak_q.size());
			$display("FAIL");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (peak_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: max_count %0d", max_count);
			end else begin
				if (max_count !== peak_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at result %0d: expected max_count %0d, got %0d",
							results_seen, peak_q[0], max_count);
				end
				void'(peak_q.pop_front());
			end
		end
	end

	initial begin
		for (int i = 0; i < N_IDS; i++)
			tally[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_saturate();
		// Anything left in flight or produced late shows up here.
		repeat (N_IDS + 16) @(posedge clk);
		if (peak_q.size() != 0)
			mismatches++;
		$display("%0d items sent, %0d results checked, %0d mismatches", items_sent,
			results_seen, mismatches);
		$display("%0d table rescans, %0d clamps at zero, %0d clamps at the top", rescans,
			floor_clamps, top_clamps);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
